/* hdl/hpfl_pkg.sv */
`default_nettype none

package hpfl_pkg;

  // handle layout and pool sizing
  localparam int MaxBlockEntries = 64;
  localparam int MaxBlocks       = 15;
  localparam int PoolCount       = 3;
  localparam int PoolShift       = 14;
  localparam int BlockShift      = 10;
  localparam int BlockSlots      = 16;

  localparam int HandleW  = 16;
  localparam int TagW     = HandleW - PoolShift;
  localparam int BlkW     = PoolShift - BlockShift;
  localparam int EntFldW  = BlockShift;
  localparam int PoolW    = 2;
  localparam int CmdW     = 2;
  localparam int CfgW     = 7;
  localparam int CfgIdxW  = 2;
  localparam int CntW     = $clog2(MaxBlocks + 1);
  localparam int EntW     = (MaxBlockEntries > 1) ? $clog2(MaxBlockEntries) : 1;
  localparam int EntriesW = $clog2(MaxBlockEntries + 1);

  // link store geometry
  localparam int LinkDepth = PoolCount * BlockSlots * MaxBlockEntries;
  localparam int LinkAw    = $clog2(LinkDepth);

  localparam logic [CfgW-1:0] EntriesReset = CfgW'(64);

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic               status;
  } res_t;

  // entries register clamped to 1 .. MaxBlockEntries
  function automatic logic [EntriesW-1:0] eff_entries(input logic [CfgW-1:0] r);
    logic [EntriesW-1:0] n;
    if (r == '0) begin
      n = EntriesW'(1);
    end else if (int'(r) > MaxBlockEntries) begin
      n = EntriesW'(MaxBlockEntries);
    end else begin
      n = EntriesW'(r);
    end
    return n;
  endfunction

  // link store address of (pool, block, entry)
  function automatic logic [LinkAw-1:0] link_addr(input logic [PoolW-1:0] p,
                                                  input logic [BlkW-1:0]  blk,
                                                  input logic [EntW-1:0]  ent);
    return LinkAw'((int'(p) * BlockSlots + int'(blk)) * MaxBlockEntries + int'(ent));
  endfunction

  // handle belongs to the pool with this tag and to a granted block
  function automatic logic handle_ok(input logic [HandleW-1:0] h,
                                     input logic [TagW-1:0]    tag,
                                     input logic [CntW-1:0]    blocks);
    logic ok;
    ok = (h[HandleW-1:PoolShift] == tag)
         && (CntW'(h[PoolShift-1:BlockShift]) < blocks)
         && (int'(h[EntFldW-1:0]) < MaxBlockEntries);
    return ok;
  endfunction

endpackage

`default_nettype wire

/* hdl/hpfl_ram.sv */
`default_nettype none

module hpfl_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/handle_pool_free_list_allocator.sv */
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   command_i pool_i handle_in_i backing_ok_i
// out       output     out_valid_o / out_stall_i handle_out_o status_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
// free, release-all and failed allocations need no link-store read; an
// allocation from a non-empty list passes through READ for the registered
// link-store read. granting a block of n entries chains entries 1..n-1 in
// FILL, one link-store write per cycle, and takes no new request meanwhile.
// reset clears heads and block counts; the link store needs no clearing.
// results queue in a two-entry output buffer; input stalls only while a
// transaction is in work or both buffer entries are full.
module handle_pool_free_list_allocator
  import hpfl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [CmdW-1:0]    command_i,
  input  wire logic [PoolW-1:0]   pool_i,
  input  wire logic [HandleW-1:0] handle_in_i,
  input  wire logic               backing_ok_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [HandleW-1:0] handle_out_o,
  output logic                    status_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_FILL = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0]    entries_q [PoolCount];
  logic [HandleW-1:0] head_q    [PoolCount];
  logic [HandleW-1:0] head_d    [PoolCount];
  logic [CntW-1:0]    blocks_q  [PoolCount];
  logic [CntW-1:0]    blocks_d  [PoolCount];

  // pending read / fill context
  logic [PoolW-1:0]    rd_pool_q, rd_pool_d;
  logic [PoolW-1:0]    fill_pool_q, fill_pool_d;
  logic [BlkW-1:0]     fill_blk_q, fill_blk_d;
  logic [EntriesW-1:0] fill_n_q, fill_n_d;
  logic [EntW-1:0]     idx_q, idx_d;

  // output buffer
  res_t       buf0_q, buf1_q;
  res_t       buf0_d, buf1_d;
  logic [1:0] cnt_q;
  res_t       res;

  // link store ports
  logic               ram_we, ram_re;
  logic [LinkAw-1:0]  ram_waddr, ram_raddr;
  logic [HandleW-1:0] ram_wdata, ram_rdata;

  logic               in_acc, out_acc;
  logic               pool_ok;
  logic [PoolW-1:0]   psel;
  logic [TagW-1:0]    tag_exp;
  logic [HandleW-1:0] head_cur, new_h;
  logic [CntW-1:0]    blocks_cur;
  logic [EntriesW-1:0] n_cur;
  logic               grant, head_ok, free_ok;
  logic [EntriesW-1:0] idx_p1;
  logic               fill_last;

  assign in_stall_o  = (state_q != S_IDLE) || (cnt_q == 2'd2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // request decode against the addressed pool
  assign pool_ok    = int'(pool_i) < PoolCount;
  assign psel       = pool_ok ? pool_i : '0;
  assign tag_exp    = TagW'(pool_i + PoolW'(1));
  assign head_cur   = head_q[psel];
  assign blocks_cur = blocks_q[psel];
  assign n_cur      = eff_entries(entries_q[psel]);
  assign new_h      = {tag_exp, BlkW'(blocks_cur), EntFldW'(0)};
  assign grant      = (head_cur == '0) && (int'(blocks_cur) < MaxBlocks) && backing_ok_i;
  assign head_ok    = (head_cur != '0) && handle_ok(head_cur, tag_exp, blocks_cur);
  assign free_ok    = pool_ok && handle_ok(handle_in_i, tag_exp, blocks_cur);

  // fill walk position
  assign idx_p1    = EntriesW'(idx_q) + EntriesW'(1);
  assign fill_last = (idx_p1 >= fill_n_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    blocks_d    = blocks_q;
    rd_pool_d   = rd_pool_q;
    fill_pool_d = fill_pool_q;
    fill_blk_d  = fill_blk_q;
    fill_n_d    = fill_n_q;
    idx_d       = idx_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = '0;
    ram_raddr   = '0;
    ram_wdata   = '0;
    res         = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (command_i)
            CMD_ALLOC: begin
              if (!pool_ok) begin
                res.status = 1'b1;
              end else if (grant) begin
                // new block: entry 0 goes out, the rest get chained
                res.handle         = new_h;
                blocks_d[psel]     = blocks_cur + CntW'(1);
                head_d[psel]       = (n_cur > EntriesW'(1)) ? new_h + HandleW'(1) : '0;
                if (n_cur > EntriesW'(1)) begin
                  state_d     = S_FILL;
                  fill_pool_d = psel;
                  fill_blk_d  = BlkW'(blocks_cur);
                  fill_n_d    = n_cur;
                  idx_d       = EntW'(1);
                end
              end else if (head_ok) begin
                // pop the head, the new head comes from the link store
                res.handle = head_cur;
                ram_re     = 1'b1;
                ram_raddr  = link_addr(psel, head_cur[PoolShift-1:BlockShift],
                                       EntW'(head_cur[EntFldW-1:0]));
                rd_pool_d  = psel;
                state_d    = S_READ;
              end else begin
                res.status = 1'b1;
              end
            end
            CMD_FREE: begin
              if (free_ok) begin
                ram_we       = 1'b1;
                ram_waddr    = link_addr(psel, handle_in_i[PoolShift-1:BlockShift],
                                         EntW'(handle_in_i[EntFldW-1:0]));
                ram_wdata    = head_cur;
                head_d[psel] = handle_in_i;
              end
            end
            CMD_RELEASE: begin
              if (pool_ok) begin
                head_d[psel]   = '0;
                blocks_d[psel] = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        head_d[rd_pool_q] = ram_rdata;
        state_d           = S_IDLE;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = link_addr(fill_pool_q, fill_blk_q, idx_q);
        ram_wdata = fill_last ? '0
                    : {TagW'(fill_pool_q + PoolW'(1)), fill_blk_q, EntFldW'(idx_p1)};
        idx_d     = EntW'(idx_p1);
        if (fill_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and pool bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < PoolCount; i++) begin
        head_q[i]    <= '0;
        blocks_q[i]  <= '0;
        entries_q[i] <= EntriesReset;
      end
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      blocks_q <= blocks_d;
      if (cfg_valid_i && cfg_ready_o && (int'(cfg_index_i) < PoolCount)) begin
        entries_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  // transaction context, no reset needed
  always_ff @(posedge clk_i) begin
    rd_pool_q   <= rd_pool_d;
    fill_pool_q <= fill_pool_d;
    fill_blk_q  <= fill_blk_d;
    fill_n_q    <= fill_n_d;
    idx_q       <= idx_d;
  end

  // output buffer count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // output buffer data: shift on pop, write behind the last live entry
  always_comb begin
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    if (out_acc) begin
      buf0_d = buf1_q;
    end
    if (in_acc) begin
      if ((cnt_q - {1'b0, out_acc}) == 2'd0) begin
        buf0_d = res;
      end else begin
        buf1_d = res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
  end

  assign handle_out_o = buf0_q.handle;
  assign status_o     = buf0_q.status;

  hpfl_ram #(
    .Width(HandleW),
    .Depth(LinkDepth)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // link read result is consumed in the cycle after issue, then back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> ($past(ram_re) && (state_d == S_IDLE)))
    else $error("link read state without a read issued the cycle before");

  // a read and a write of the link store never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("link store read and write in the same cycle");

  // no input taken while the buffer is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_acc)
    else $error("output buffer overflow");

  // block count stays within the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(blocks_q[psel]) <= MaxBlocks))
    else $error("block count above limit");

  // a non-empty head always carries its own pool tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pool_ok && (head_cur != '0)) |-> (head_cur[HandleW-1:PoolShift] == tag_exp))
    else $error("free-list head tagged for another pool");

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench
  import hpfl_pkg::*;
();

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_POOL0_ENTRIES = 2'd0,
    REG_POOL1_ENTRIES = 2'd1,
    REG_POOL2_ENTRIES = 2'd2
  } reg_e;

  // command and pool codes outside the defined range
  localparam logic [CmdW-1:0]  CMD_UNKNOWN = 2'd3;
  localparam logic [PoolW-1:0] POOL_NONE   = 2'd3;

  localparam int QuietLimit  = 3000;
  localparam int SettleWait  = 80;
  localparam int HoldCycles  = 250;
  localparam int HoldAfter   = 60;

  // expected replies and the allocator state they follow from
  class alloc_ledger;
    logic [CfgW-1:0]    entries_cfg [PoolCount];
    logic [HandleW-1:0] free_head [PoolCount];
    int unsigned        blocks_out [PoolCount];
    logic [HandleW-1:0] link_mem [int];
    res_t               pending_replies [$];
    logic [HandleW-1:0] live_handles [$];
    int                 errors;
    int                 requests_noted;

    function new();
      for (int p = 0; p < PoolCount; p++) begin
        entries_cfg[p] = EntriesReset;
        free_head[p]   = '0;
        blocks_out[p]  = 0;
      end
      errors = 0;
      requests_noted = 0;
    endfunction

    // entries per block after clamping the register
    function int block_size(int p);
      int n;
      n = entries_cfg[p];
      if (n < 1) n = 1;
      if (n > MaxBlockEntries) n = MaxBlockEntries;
      return n;
    endfunction

    function int slot_of(int p, logic [HandleW-1:0] h);
      return (p * BlockSlots + int'(h[PoolShift-1:BlockShift])) * MaxBlockEntries
             + int'(h[EntFldW-1:0]);
    endfunction

    // handle tagged for pool p, in a granted block, entry in range
    function bit owns(int p, logic [HandleW-1:0] h);
      return (int'(h[HandleW-1:PoolShift]) == p + 1)
             && (int'(h[PoolShift-1:BlockShift]) < blocks_out[p])
             && (int'(h[EntFldW-1:0]) < MaxBlockEntries);
    endfunction

    function void set_entries(int p, logic [CfgW-1:0] value);
      entries_cfg[p] = value;
    endfunction

    // note an accepted request and queue the reply it must produce
    function void predict_request(logic [CmdW-1:0] cmd, logic [PoolW-1:0] pool,
                                  logic [HandleW-1:0] hin, logic backing);
      res_t               reply;
      int                 p;
      int                 blk;
      int                 n;
      logic [HandleW-1:0] h;
      logic [HandleW-1:0] keep [$];
      reply = '0;
      p = int'(pool);
      requests_noted++;
      case (cmd)
        CMD_ALLOC: begin
          if (p >= PoolCount) begin
            reply.status = 1'b1;
          end else begin
            h = free_head[p];
            // empty list: grant a fresh block and chain its entries
            if (h == '0 && blocks_out[p] < MaxBlocks && backing) begin
              blk = blocks_out[p];
              n = block_size(p);
              h = {TagW'(p + 1), BlkW'(blk), EntFldW'(0)};
              for (int i = 0; i < n; i++) begin
                link_mem[slot_of(p, h + HandleW'(i))] = (i + 1 < n) ? h + HandleW'(i + 1) : '0;
              end
              blocks_out[p] = blk + 1;
            end
            if (h != '0 && owns(p, h)) begin
              free_head[p] = link_mem[slot_of(p, h)];
              reply.handle = h;
              live_handles.push_back(h);
            end else begin
              reply.status = 1'b1;
            end
          end
        end
        CMD_FREE: begin
          if (p < PoolCount && owns(p, hin)) begin
            link_mem[slot_of(p, hin)] = free_head[p];
            free_head[p] = hin;
          end
        end
        CMD_RELEASE: begin
          if (p < PoolCount) begin
            free_head[p] = '0;
            blocks_out[p] = 0;
            // handles of this pool are stale now
            foreach (live_handles[i]) begin
              if (int'(live_handles[i][HandleW-1:PoolShift]) != p + 1) begin
                keep.push_back(live_handles[i]);
              end
            end
            live_handles = keep;
          end
        end
        default: begin
        end
      endcase
      pending_replies.push_back(reply);
    endfunction

    // compare an accepted reply with the oldest expectation
    function void compare_reply(logic [HandleW-1:0] h, logic st);
      res_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual handle %h status %0d",
                 $time, h, st);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (h !== want.handle) begin
          $display("%0t: handle_out mismatch, expected %h actual %h", $time, want.handle, h);
          errors++;
        end
        if (st !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status, st);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [CmdW-1:0]    command_i = CMD_ALLOC;
  logic [PoolW-1:0]   pool_i = '0;
  logic [HandleW-1:0] handle_in_i = '0;
  logic               backing_ok_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [HandleW-1:0] handle_out_o;
  logic               status_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = REG_POOL0_ENTRIES;
  logic [CfgW-1:0]    cfg_data_i = '0;

  bit          steady_rate = 1'b0;
  alloc_ledger ledger = new();

  handle_pool_free_list_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .pool_i       (pool_i),
    .handle_in_i  (handle_in_i),
    .backing_ok_i (backing_ok_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .handle_out_o (handle_out_o),
    .status_o     (status_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [PoolW-1:0] pool,
                              input logic [HandleW-1:0] hin, input logic backing);
    while (!steady_rate && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    pool_i       <= pool;
    handle_in_i  <= hin;
    backing_ok_i <= backing;
    do @(posedge clk_i); while (in_stall_o);
    ledger.predict_request(cmd, pool, hin, backing);
  endtask

  // wait for every reply and for a block walk to finish, then program all pools
  task automatic reprogram(input logic [CfgW-1:0] e0, input logic [CfgW-1:0] e1,
                           input logic [CfgW-1:0] e2);
    logic [CfgW-1:0] vals [PoolCount];
    vals[0] = e0;
    vals[1] = e1;
    vals[2] = e2;
    in_valid_i <= 1'b0;
    while (ledger.pending_replies.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
    for (int p = 0; p < PoolCount; p++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_e'(p);
      cfg_data_i  <= vals[p];
      do @(posedge clk_i); while (!cfg_ready_o);
      ledger.set_entries(p, vals[p]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed alloc and free traffic, some invalid frees and noise
  task automatic random_traffic(input int count);
    int                 roll;
    int                 pick;
    logic [CmdW-1:0]    cmd;
    logic [PoolW-1:0]   pool;
    logic [HandleW-1:0] hin;
    logic               backing;
    repeat (count) begin
      roll    = $urandom_range(0, 99);
      cmd     = CMD_ALLOC;
      pool    = PoolW'($urandom_range(0, PoolCount - 1));
      hin     = HandleW'($urandom);
      backing = ($urandom_range(0, 9) != 0);
      if (roll < 45) begin
        cmd = CMD_ALLOC;
      end else if (roll < 78 && ledger.live_handles.size() > 0) begin
        // return a handle that is out, now and then without forgetting it
        cmd  = CMD_FREE;
        pick = $urandom_range(0, ledger.live_handles.size() - 1);
        hin  = ledger.live_handles[pick];
        pool = PoolW'(hin[HandleW-1:PoolShift] - 1);
        if ($urandom_range(0, 19) != 0) ledger.live_handles.delete(pick);
      end else if (roll < 87) begin
        // well-tagged handle with random block and entry
        cmd = CMD_FREE;
        hin = {TagW'(pool + 1), BlkW'($urandom_range(0, BlockSlots - 1)),
               EntFldW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, MaxBlockEntries - 1))};
      end else if (roll < 91) begin
        cmd  = CMD_FREE;
        pool = PoolW'($urandom_range(0, 3));
      end else if (roll < 94) begin
        cmd = CMD_RELEASE;
      end else if (roll < 97) begin
        cmd  = CmdW'($urandom_range(0, 3));
        pool = POOL_NONE;
      end else begin
        cmd = CMD_UNKNOWN;
      end
      send_request(cmd, pool, hin, backing);
    end
  endtask

  // reply side: check accepted replies, stall at random, one long hold-off
  initial begin : reply_sink
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) ledger.compare_reply(handle_out_o, status_o);
      if (!held && ledger.requests_noted >= HoldAfter) begin
        held = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady_rate && ($urandom_range(0, 99) < 11);
      end
    end
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL handle_pool_free_list_allocator");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, grants, double free, invalid handles, odd codes
    send_request(CMD_ALLOC, 2'd0, 16'h0000, 1'b0);
    send_request(CMD_ALLOC, 2'd0, 16'hFFFF, 1'b1);
    send_request(CMD_ALLOC, 2'd0, 16'h0000, 1'b1);
    send_request(CMD_FREE, 2'd0, 16'h4001, 1'b0);
    send_request(CMD_FREE, 2'd0, 16'h4001, 1'b1);
    send_request(CMD_ALLOC, 2'd0, 16'h0000, 1'b1);
    send_request(CMD_ALLOC, 2'd0, 16'h0000, 1'b0);
    send_request(CMD_ALLOC, POOL_NONE, 16'h0000, 1'b1);
    send_request(CMD_FREE, POOL_NONE, 16'hC000, 1'b1);
    send_request(CMD_RELEASE, POOL_NONE, 16'h0000, 1'b1);
    send_request(CMD_FREE, 2'd0, 16'h0000, 1'b1);
    send_request(CMD_FREE, 2'd0, 16'h8000, 1'b1);
    send_request(CMD_FREE, 2'd0, 16'h4400, 1'b1);
    send_request(CMD_FREE, 2'd0, 16'h4040, 1'b1);
    send_request(CMD_FREE, 2'd0, 16'h7FFF, 1'b1);
    send_request(CMD_FREE, 2'd1, 16'hFFFF, 1'b1);
    send_request(CMD_UNKNOWN, 2'd0, 16'hFFFF, 1'b1);
    send_request(CMD_ALLOC, 2'd1, 16'h0000, 1'b1);
    send_request(CMD_ALLOC, 2'd2, 16'h0000, 1'b1);
    send_request(CMD_FREE, 2'd0, 16'h403F, 1'b1);
    send_request(CMD_RELEASE, 2'd0, 16'h0000, 1'b0);
    send_request(CMD_ALLOC, 2'd0, 16'h0000, 1'b0);
    send_request(CMD_ALLOC, 2'd0, 16'h0000, 1'b1);
    send_request(CMD_FREE, 2'd2, 16'hC000, 1'b0);

    // random phases over several block sizes, extremes included
    random_traffic(280);
    reprogram(7'd1, 7'd2, 7'd3);
    random_traffic(310);
    reprogram(7'd0, 7'd127, 7'd65);
    random_traffic(310);
    reprogram(7'd64, 7'd1, 7'd7);
    steady_rate = 1'b1;
    random_traffic(310);
    steady_rate = 1'b0;
    reprogram(7'd2, 7'd64, 7'd1);
    random_traffic(310);
    reprogram(7'd33, 7'd4, 7'd64);
    random_traffic(310);

    // drain
    in_valid_i <= 1'b0;
    while (ledger.pending_replies.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.pending_replies.size() == 0) begin
      $display("PASS handle_pool_free_list_allocator");
    end else begin
      $display("FAIL handle_pool_free_list_allocator");
    end
    $finish;
  end

endmodule
